@@ src/skf_pkg.sv @@
// Shared types, constants and helpers for the scalar Kalman filter unit.
// Used by skf_div, scalar_kalman_filter_unit and tb_top; depends on nothing.
package skf_pkg;

    // Q16.16 sample and estimate width
    localparam int VALUE_W   = 32;
    // Fraction bits of covariance (Q2.x) and gain (Q0.x)
    localparam int COV_FRAC  = 30;
    localparam int COV_W     = COV_FRAC + 2;
    localparam int REG_W     = COV_W;
    localparam int CFG_IDX_W = 2;

    // Multiplier operands: gain-like value (Q1.x) times magnitude or covariance
    localparam int MUL_A_W   = COV_FRAC + 1;
    localparam int MUL_B_W   = (VALUE_W > COV_W) ? VALUE_W : COV_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SHR_W     = PROD_W - COV_FRAC;

    // Estimate update headroom
    localparam int EST_W     = VALUE_W + 3;

    localparam int DIV_CNT_W = $clog2(COV_FRAC);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COV_FRAC - 1);

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

    localparam logic [REG_W-1:0]     Q_RESET   = REG_W'(1073742);
    localparam logic [REG_W-1:0]     R_RESET   = REG_W'(10737418);
    localparam logic [COV_W-1:0]     COV_ONE   = COV_W'(1) << COV_FRAC;
    localparam logic [COV_FRAC-1:0]  GAIN_MAX  = '1;
    localparam logic [MUL_A_W-1:0]   GAIN_ONE  = MUL_A_W'(1) << COV_FRAC;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_DEN,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL_GAIN,
        S_EST,
        S_MUL_COV,
        S_COV,
        S_DONE
    } t_state;

    // Saturating covariance add
    function automatic logic [COV_W-1:0] sat_add_cov(input logic [COV_W-1:0] a,
                                                     input logic [COV_W-1:0] b);
        logic [COV_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COV_W] ? {COV_W{1'b1}} : sum[COV_W-1:0];
    endfunction

endpackage

@@ src/scalar_kalman_filter_unit.sv @@
// Scalar Kalman filter: one filtered Q16.16 estimate per Q16.16 sample.
// Depends on skf_pkg and skf_div.
//
//  Channel   Direction  Handshake                 Payload
//  sample    in         i_in_valid / o_in_stall   i_sample
//  estimate  out        o_out_valid / i_out_stall o_estimate
//  config    in         i_cfg_we, i_cfg_index     i_cfg_data (0: Q, 1: R)
//
// The restoring gain divider forms one quotient bit a cycle. When the
// denominator is zero or the gain saturates, the divider skips its loop.
// One shared 31 x 32 multiplier forms the correction and the new covariance.
// Synchronous active-low reset clears the estimate to 0, the covariance to 1.0
// and the noise registers to their defaults. The input stalls while an item is
// in work; a stalled result waits in the output register and holds back only
// the final step of the next item.
module scalar_kalman_filter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [skf_pkg::VALUE_W-1:0]   i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [skf_pkg::VALUE_W-1:0]   o_estimate,
    input  logic                                 i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [skf_pkg::REG_W-1:0]            i_cfg_data
);
    import skf_pkg::*;

    t_state r_state, n_state;

    logic [REG_W-1:0]           r_q, r_r;
    logic signed [VALUE_W-1:0]  r_est;
    logic [COV_W-1:0]           r_cov;
    logic signed [VALUE_W-1:0]  r_sample;
    logic [COV_W-1:0]           r_pred;
    logic [COV_W-1:0]           r_den;
    logic                       r_neg;
    logic [VALUE_W-1:0]         r_mag;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_est;

    logic accept, out_free;
    logic ld_pred, ld_den, div_start, ld_prod_gain, ld_est, ld_prod_cov, ld_cov, ld_out;
    logic div_done;
    logic [COV_FRAC-1:0] gain;

    logic signed [VALUE_W:0]    diff;
    logic [VALUE_W:0]           diff_abs;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PROD_W-1:0]          product;
    logic [SHR_W-1:0]           prod_shr;
    logic                       prod_rest;
    logic [EST_W-1:0]           corr_mag;
    logic signed [EST_W-1:0]    corr;
    logic signed [EST_W-1:0]    est_sum;
    logic signed [VALUE_W-1:0]  est_next;
    logic [COV_W-1:0]           cov_next;

    skf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      (r_pred),
        .i_den      (r_den),
        .o_done     (div_done),
        .o_quotient (gain)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_PRED;
            S_PRED:      n_state = S_DEN;
            S_DEN:       n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (div_done) n_state = S_MUL_GAIN;
            S_MUL_GAIN:  n_state = S_EST;
            S_EST:       n_state = S_MUL_COV;
            S_MUL_COV:   n_state = S_COV;
            S_COV:       n_state = S_DONE;
            S_DONE:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        o_in_stall   = 1'b1;
        ld_pred      = 1'b0;
        ld_den       = 1'b0;
        div_start    = 1'b0;
        ld_prod_gain = 1'b0;
        ld_est       = 1'b0;
        ld_prod_cov  = 1'b0;
        ld_cov       = 1'b0;
        ld_out       = 1'b0;
        case (r_state)
            S_IDLE:      o_in_stall   = 1'b0;
            S_PRED:      ld_pred      = 1'b1;
            S_DEN:       ld_den       = 1'b1;
            S_DIV_START: div_start    = 1'b1;
            S_DIV_WAIT:  ;
            S_MUL_GAIN:  ld_prod_gain = 1'b1;
            S_EST:       ld_est       = 1'b1;
            S_MUL_COV:   ld_prod_cov  = 1'b1;
            S_COV:       ld_cov       = 1'b1;
            S_DONE:      ld_out       = out_free;
            default:     ;
        endcase
    end

    // innovation sign and magnitude
    always_comb begin
        diff     = (VALUE_W+1)'(r_sample) - (VALUE_W+1)'(r_est);
        diff_abs = diff[VALUE_W] ? (VALUE_W+1)'(-diff) : diff;
    end

    // shared multiplier
    always_comb begin
        if (ld_prod_cov) begin
            mul_a = GAIN_ONE - {1'b0, gain};
            mul_b = MUL_B_W'(r_pred);
        end else begin
            mul_a = {1'b0, gain};
            mul_b = MUL_B_W'(r_mag);
        end
        product = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // estimate update: correction rounds toward minus infinity
    always_comb begin
        prod_shr  = r_prod[PROD_W-1:COV_FRAC];
        prod_rest = |r_prod[COV_FRAC-1:0];
        if (r_neg) begin
            corr_mag = EST_W'(prod_shr) + EST_W'(prod_rest);
            corr     = -signed'(corr_mag);
        end else begin
            corr_mag = EST_W'(prod_shr);
            corr     = signed'(corr_mag);
        end
        est_sum = EST_W'(r_est) + corr;
        if (est_sum[EST_W-1:VALUE_W-1] == '0 || est_sum[EST_W-1:VALUE_W-1] == '1) begin
            est_next = est_sum[VALUE_W-1:0];
        end else if (est_sum[EST_W-1]) begin
            est_next = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            est_next = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        // clamp the truncated covariance to the Q2.x range
        if (prod_shr[SHR_W-1:COV_W] != '0) begin
            cov_next = '1;
        end else begin
            cov_next = prod_shr[COV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q         <= Q_RESET;
            r_r         <= R_RESET;
            r_est       <= '0;
            r_cov       <= COV_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROCESS_NOISE:     r_q <= i_cfg_data;
                    REG_MEASUREMENT_NOISE: r_r <= i_cfg_data;
                    default:               ;
                endcase
            end
            if (ld_est) r_est <= est_next;
            if (ld_cov) r_cov <= cov_next;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) r_sample <= i_sample;
        if (ld_pred) r_pred <= sat_add_cov(r_cov, r_q);
        if (ld_den) begin
            r_den <= sat_add_cov(r_pred, r_r);
            r_neg <= diff[VALUE_W];
            r_mag <= diff_abs[VALUE_W-1:0];
        end
        if (ld_prod_gain || ld_prod_cov) r_prod <= product;
        if (ld_out) r_out_est <= r_est;
    end

    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out_est;

endmodule

@@ src/skf_div.sv @@
// Iterative restoring divider for the Kalman gain: one quotient bit a cycle.
// Depends on skf_pkg.
module skf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [skf_pkg::COV_W-1:0]     i_num,
    input  logic [skf_pkg::COV_W-1:0]     i_den,
    output logic                          o_done,
    output logic [skf_pkg::COV_FRAC-1:0]  o_quotient
);
    import skf_pkg::*;

    logic [COV_W-1:0]     r_rem, n_rem;
    logic [COV_W-1:0]     r_den, n_den;
    logic [COV_FRAC-1:0]  r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    logic [COV_W:0]       shifted;
    logic [COV_W:0]       trial;

    always_comb begin
        shifted = {r_rem, 1'b0};
        trial   = shifted - {1'b0, r_den};
    end

    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_den = i_den;
            n_rem = i_num;
            n_cnt = '0;
            if (i_den == '0) begin
                n_quo  = '0;
                n_done = 1'b1;
            end else if (i_num >= i_den) begin
                // gain of one saturates just below one
                n_quo  = GAIN_MAX;
                n_done = 1'b1;
            end else begin
                n_quo  = '0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            // no borrow: subtract and set the quotient bit
            if (!trial[COV_W]) begin
                n_rem = trial[COV_W-1:0];
                n_quo = {r_quo[COV_FRAC-2:0], 1'b1};
            end else begin
                n_rem = shifted[COV_W-1:0];
                n_quo = {r_quo[COV_FRAC-2:0], 1'b0};
            end
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for scalar_kalman_filter_unit: drives Q16.16 samples, predicts
// each filtered estimate with a bit-accurate fixed-point Kalman update, and checks it.
// Depends on skf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_top;
    import skf_pkg::*;

    localparam int TIMEOUT_NS     = 1_000_000;
    localparam int ITEM_CYCLES    = COV_FRAC + 10;
    localparam int MAX_REPORTS    = 10;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 50;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

    localparam logic signed [63:0] EST_HI = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
    localparam logic signed [63:0] EST_LO = -(64'sd1 <<< (VALUE_W - 1));

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [VALUE_W-1:0]   i_sample = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [VALUE_W-1:0]   o_estimate;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [REG_W-1:0]            i_cfg_data = '0;

    // Filter state and noise registers as the bench sees them
    logic signed [VALUE_W-1:0]   est_model = '0;
    logic [COV_W-1:0]            cov_model = COV_ONE;
    logic [REG_W-1:0]            q_model = Q_RESET;
    logic [REG_W-1:0]            r_model = R_RESET;

    logic signed [VALUE_W-1:0]   sample_queue[$];
    logic signed [VALUE_W-1:0]   estimate_queue[$];
    int unsigned                 issued = 0;
    int unsigned                 retired = 0;
    int unsigned                 failures = 0;
    bit                          idling = 1'b1;
    int unsigned                 in_gap = 0;
    int unsigned                 stall_left = 0;

    scalar_kalman_filter_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_estimate  (o_estimate),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // One Kalman step: advance the estimate and covariance, return the new estimate
    function automatic logic signed [VALUE_W-1:0] kalman_update(
        input logic signed [VALUE_W-1:0] sample);
        logic [COV_W:0]        sum;
        logic [COV_W-1:0]      pred;
        logic [COV_W-1:0]      den;
        logic [COV_FRAC-1:0]   gain;
        logic [63:0]           quot;
        logic [63:0]           cov_prod;
        logic signed [63:0]    diff;
        logic signed [63:0]    corr;
        logic signed [63:0]    next_est;
        sum  = {1'b0, cov_model} + {1'b0, q_model};
        pred = sum[COV_W] ? '1 : sum[COV_W-1:0];
        sum  = {1'b0, pred} + {1'b0, r_model};
        den  = sum[COV_W] ? '1 : sum[COV_W-1:0];
        if (den == '0) begin
            gain = '0;
        end else if (pred >= den) begin
            gain = '1;
        end else begin
            quot = (64'(pred) << COV_FRAC) / 64'(den);
            gain = quot[COV_FRAC-1:0];
        end
        diff = 64'(sample) - 64'(est_model);
        // arithmetic shift floors the correction for both signs
        corr = ($signed(64'(gain)) * diff) >>> COV_FRAC;
        next_est = 64'(est_model) + corr;
        if (next_est > EST_HI) begin
            next_est = EST_HI;
        end else if (next_est < EST_LO) begin
            next_est = EST_LO;
        end
        est_model = next_est[VALUE_W-1:0];
        cov_prod = (64'(GAIN_ONE) - 64'(gain)) * 64'(pred);
        cov_model = cov_prod[COV_FRAC +: COV_W];
        return est_model;
    endfunction

    function automatic logic [REG_W-1:0] pick_noise();
        case ($urandom_range(0, 4))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return REG_W'($urandom_range(1, 1 << 20));
            end
            default: begin
                return REG_W'($urandom);
            end
        endcase
    endfunction

    // Sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                estimate_queue.push_back(kalman_update(i_sample));
            end
            // hold the payload while a transaction is stalled
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (idling && $urandom_range(0, 5) == 0) begin
                    in_gap <= $urandom_range(0, 14);
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_sample <= sample_queue.pop_front();
                    issued++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Estimate monitor
    always @(posedge i_clk) begin
        logic signed [VALUE_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (estimate_queue.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("unexpected estimate 0x%08h", o_estimate);
                    end
                end else begin
                    want = estimate_queue.pop_front();
                    retired++;
                    if (o_estimate !== want) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("estimate mismatch: expected 0x%08h, got 0x%08h",
                                     want, o_estimate);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 14);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PROCESS_NOISE) begin
            q_model = data;
        end else if (idx == REG_MEASUREMENT_NOISE) begin
            r_model = data;
        end
    endtask

    task automatic set_noise(input logic [REG_W-1:0] q, input logic [REG_W-1:0] r);
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASUREMENT_NOISE, r);
    endtask

    // Wait until every queued sample has come back as an estimate
    task automatic drain();
        while (sample_queue.size() != 0 || issued != retired) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic signed [VALUE_W-1:0] extremes[8];
        logic [VALUE_W-1:0]        level;
        logic [VALUE_W-1:0]        mask;
        logic [VALUE_W-1:0]        s;
        extremes = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000, 32'shFFFF_0000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default noise: full-scale swings of the sample
        foreach (extremes[k]) begin
            sample_queue.push_back(extremes[k]);
        end
        drain();

        // No noise at all: gain saturates just below one, then the covariance
        // collapses to zero and the zero denominator forces a zero gain.
        // Writes to undecoded indexes must leave both registers alone.
        set_noise('0, '0);
        write_reg(REG_RESERVED, REG_W'($urandom));
        write_reg(REG_UNMAPPED, REG_W'($urandom));
        sample_queue.push_back(32'sh0002_0000);
        sample_queue.push_back(32'sh8000_0000);
        sample_queue.push_back(32'sh7FFF_FFFF);
        sample_queue.push_back(32'sh1234_5678);
        sample_queue.push_back(32'sh0000_0000);
        drain();

        // Both sums saturate
        set_noise('1, '1);
        sample_queue.push_back(32'sh8000_0000);
        sample_queue.push_back(32'sh7FFF_FFFF);
        sample_queue.push_back(32'sh0000_0000);
        drain();

        // Tiny gain, then a gain saturated just below one with R at zero
        set_noise('0, '1);
        sample_queue.push_back(32'sh7FFF_FFFF);
        sample_queue.push_back(32'sh8000_0000);
        sample_queue.push_back(32'sh0100_0000);
        drain();
        set_noise('1, '0);
        sample_queue.push_back(32'sh8000_0000);
        sample_queue.push_back(32'sh7FFF_FFFF);
        sample_queue.push_back(32'shFFFF_FFFF);
        drain();

        // Noisy steady levels with occasional steps and outliers
        for (int p = 0; p < RAND_PHASES; p++) begin
            idling = (p != 3) && (p != RAND_PHASES - 1);
            if (p == RAND_PHASES - 1) begin
                set_noise(Q_RESET, R_RESET);
            end else begin
                set_noise(pick_noise(), pick_noise());
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_UNMAPPED, REG_W'($urandom));
            end
            level = $urandom;
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                mask = (32'd1 << $urandom_range(0, 24)) - 32'd1;
                if ($urandom_range(0, 9) == 0) begin
                    s = $urandom;
                end else begin
                    s = level + ($urandom & mask) - (mask >> 1);
                end
                if ($urandom_range(0, 49) == 0) begin
                    level = $urandom;
                end
                sample_queue.push_back(s);
            end
            drain();
        end

        repeat (ITEM_CYCLES + 10) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
